// ===== hw/rtl/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants for the packed field array.
// Holds field widths, operation and status codes, controller states and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int OP_W     = 3;
  localparam int IDX_W    = 13;
  localparam int BITS_W   = 6;
  localparam int COUNT_W  = 14;
  localparam int WORD_W   = 32;
  localparam int STAT_W   = 2;
  localparam int CFG_A_W  = 1;
  localparam int CFG_D_W  = 14;
  localparam int OFF_W    = 5;

  // Configuration register indexes.
  localparam logic [CFG_A_W-1:0] CFG_ELEMENT_BITS  = 1'b0;
  localparam logic [CFG_A_W-1:0] CFG_ELEMENT_COUNT = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_GET    = 3'd0,
    OP_SET    = 3'd1,
    OP_TOGGLE = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_FILL   = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_WIDTH = 2'd1,
    STAT_SIZE  = 2'd2,
    STAT_INDEX = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RD0,
    S_RD1,
    S_RD2,
    S_WR0,
    S_WR1,
    S_CLR,
    S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic fill_init;
    logic fill_step;
    logic rd_lo;
    logic rd_hi;
    logic cap_lo;
    logic merge;
    logic wr_lo;
    logic wr_hi;
    logic clr_init;
    logic clr_write;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic            bad;
    logic [OP_W-1:0] op;
    logic            straddle;
    logic            fill_last;
    logic            count_zero;
    logic            clr_last;
  } dp_status_t;

endpackage

// ===== hw/rtl/pfa_if.sv =====
// ----------------------------------------------------------------------------
// pfa_if: channel interfaces of the packed field array.
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface pfa_req_if import pfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [IDX_W-1:0]  element_index;
  logic [WORD_W-1:0] write_value;

  modport source (output valid, op, element_index, write_value, input ready);
  modport sink   (input valid, op, element_index, write_value, output ready);
endinterface

interface pfa_rsp_if import pfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] read_value;
  status_t           status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

interface pfa_cfg_if import pfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CFG_A_W-1:0] addr;
  logic [CFG_D_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ===== hw/rtl/pfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfa_ctrl: operation sequencer of the packed field array.
// Steps the datapath through check, word reads, merge, word writes,
// store sweeps and result hand-off.
// ----------------------------------------------------------------------------
module pfa_ctrl import pfa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  logic        out_valid, out_valid_next;
  logic        out_free;

  assign out_free  = !out_valid || rsp_ready;
  assign rsp_valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;

    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.bad) begin
          state_next = S_FINISH;
        end else begin
          case (op_t'(sts.op))
            OP_GET, OP_SET, OP_TOGGLE: state_next = S_RD0;
            OP_CLEAR: begin
              cmd.clr_init = 1'b1;
              state_next   = S_CLR;
            end
            OP_FILL: begin
              if (sts.count_zero) begin
                state_next = S_FINISH;
              end else begin
                cmd.fill_init = 1'b1;
                state_next    = S_RD0;
              end
            end
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_RD0: begin
        cmd.rd_lo  = 1'b1;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.cap_lo = 1'b1;
        cmd.rd_hi  = 1'b1;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.merge  = 1'b1;
        state_next = (sts.op == OP_GET) ? S_FINISH : S_WR0;
      end
      S_WR0, S_WR1: begin
        if (state == S_WR0) begin
          cmd.wr_lo = 1'b1;
        end else begin
          cmd.wr_hi = 1'b1;
        end
        if (state == S_WR0 && sts.straddle) begin
          state_next = S_WR1;
        end else if (sts.op == OP_FILL && !sts.fill_last) begin
          cmd.fill_step = 1'b1;
          state_next    = S_RD0;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_CLR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_valid && rsp_ready) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

// ===== hw/rtl/pfa_datapath.sv =====
// ----------------------------------------------------------------------------
// pfa_datapath: storage and arithmetic of the packed field array.
// Configuration registers, validity checks, the word memory, element
// extract and merge, fill and clear counters, and the result register.
// ----------------------------------------------------------------------------
module pfa_datapath import pfa_pkg::*; #(
  parameter int MAX_BYTES        = 1024,
  parameter int MAX_ELEMENT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_D_W-1:0] cfg_data,
  input  logic [OP_W-1:0]    in_op,
  input  logic [IDX_W-1:0]   in_index,
  input  logic [WORD_W-1:0]  in_value,
  input  dp_cmd_t            cmd,
  output dp_status_t         sts,
  output logic [WORD_W-1:0]  read_value,
  output status_t            status
);

  localparam int STORE_WORDS = (MAX_BYTES + 3) / 4;
  localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int POS_W       = AW + OFF_W;
  localparam int PROD_W      = IDX_W + BITS_W;
  localparam int SIZE_W      = BITS_W + COUNT_W;
  localparam logic [SIZE_W:0]   SIZE_LIMIT = (SIZE_W + 1)'(8 * MAX_BYTES);
  localparam logic [BITS_W:0]   BITS_LIMIT = (BITS_W + 1)'(MAX_ELEMENT_BITS);
  localparam logic [AW-1:0]     LAST_WORD  = AW'(STORE_WORDS - 1);

  // Configuration registers.
  logic [BITS_W-1:0]  elem_bits;
  logic [COUNT_W-1:0] elem_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_bits  <= '0;
      elem_count <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ELEMENT_BITS:  elem_bits  <= cfg_data[BITS_W-1:0];
        CFG_ELEMENT_COUNT: elem_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Item registers.
  logic [OP_W-1:0]   op;
  logic [IDX_W-1:0]  idx;
  logic [WORD_W-1:0] val;
  logic [POS_W-1:0]  pos;
  status_t           st;
  logic [WORD_W-1:0] res;
  logic [WORD_W-1:0] lo;
  logic [WORD_W-1:0] hi;
  logic [AW-1:0]     clr_addr;

  // Checks made as the item is taken.
  logic [PROD_W-1:0] pos_prod;
  logic [SIZE_W-1:0] size_prod;
  logic              width_bad, size_bad, index_bad, elem_op;
  status_t           st_new;

  assign pos_prod  = PROD_W'(in_index) * PROD_W'(elem_bits);
  assign size_prod = SIZE_W'(elem_bits) * SIZE_W'(elem_count);
  assign width_bad = (elem_bits == '0) || ({1'b0, elem_bits} > BITS_LIMIT);
  assign size_bad  = {1'b0, size_prod} > SIZE_LIMIT;
  assign elem_op   = (in_op == OP_GET) || (in_op == OP_SET) || (in_op == OP_TOGGLE);
  assign index_bad = elem_op && ({1'b0, in_index} >= elem_count);

  always_comb begin
    if (in_op > OP_FILL) begin
      st_new = STAT_OK;
    end else if (width_bad) begin
      st_new = STAT_WIDTH;
    end else if (size_bad) begin
      st_new = STAT_SIZE;
    end else if (index_bad) begin
      st_new = STAT_INDEX;
    end else begin
      st_new = STAT_OK;
    end
  end

  // Element geometry.
  logic [OFF_W-1:0]    off;
  logic [AW-1:0]       w0, w1;
  logic [WORD_W-1:0]   mask;
  logic [2*WORD_W-1:0] window, shifted, merged;
  logic [WORD_W-1:0]   elem, nv;
  logic [WORD_W-1:0]   rdata;

  assign off  = pos[OFF_W-1:0];
  assign w0   = pos[POS_W-1:OFF_W];
  assign w1   = w0 + 1'b1;
  assign mask = {WORD_W{1'b1}} >> (BITS_W'(WORD_W) - elem_bits);

  assign sts.bad        = (st != STAT_OK);
  assign sts.op         = op;
  assign sts.straddle   = ({2'b0, off} + {1'b0, elem_bits}) > (BITS_W + 1)'(WORD_W);
  assign sts.fill_last  = ({1'b0, idx} + 1'b1) == elem_count;
  assign sts.count_zero = (elem_count == '0);
  assign sts.clr_last   = (clr_addr == LAST_WORD);

  // Extract from the two fetched words and merge the new value back.
  assign window  = {rdata, lo};
  assign shifted = window >> off;
  assign elem    = shifted[WORD_W-1:0] & mask;
  assign nv      = (op == OP_TOGGLE) ? (~elem & mask) : (val & mask);
  assign merged  = (window & ~({{WORD_W{1'b0}}, mask} << off))
                 | ({{WORD_W{1'b0}}, nv} << off);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op  <= in_op;
      idx <= in_index;
      val <= in_value;
      pos <= POS_W'(pos_prod);
      st  <= st_new;
      res <= '0;
    end else if (cmd.fill_init) begin
      idx <= '0;
      pos <= '0;
    end else if (cmd.fill_step) begin
      idx <= idx + 1'b1;
      pos <= pos + POS_W'(elem_bits);
    end
    if (cmd.cap_lo) begin
      lo <= rdata;
    end
    if (cmd.merge) begin
      lo <= merged[WORD_W-1:0];
      hi <= merged[2*WORD_W-1:WORD_W];
      case (op)
        OP_GET:    res <= elem;
        OP_SET:    res <= val;
        OP_TOGGLE: res <= nv;
        default: ;
      endcase
    end
    if (cmd.clr_init) begin
      clr_addr <= '0;
    end else if (cmd.clr_write) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Word memory: one write port, one registered read port.
  logic [WORD_W-1:0] mem [STORE_WORDS];
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [WORD_W-1:0] wdata;

  assign we    = cmd.wr_lo || cmd.wr_hi || cmd.clr_write;
  assign waddr = cmd.clr_write ? clr_addr : (cmd.wr_hi ? w1 : w0);
  assign wdata = cmd.clr_write ? '0 : (cmd.wr_hi ? hi : lo);
  assign re    = cmd.rd_lo || cmd.rd_hi;
  assign raddr = (cmd.rd_hi && sts.straddle) ? w1 : w0;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      read_value <= res;
      status     <= st;
    end
  end

endmodule

// ===== hw/rtl/packed_field_array.sv =====
// ----------------------------------------------------------------------------
// packed_field_array: packed bit-field store with get, set, toggle, clear
// and fill.
// Elements of 1 to 32 bits lie edge to edge in a word memory and may cross
// a word boundary; each request returns one beat of value and status.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Beat contents                         Handshake
//   req      in   op, element_index, write_value        valid/ready
//   rsp      out  read_value, status                    valid/ready
//   cfg      in   addr (0 element_bits, 1 count), data  valid/ready (ready high)
//
// Operation: one request is worked at a time. After the check, a get reads
// the two words that hold the element and extracts it; a set or toggle also
// writes the first word back, and the second too when the element crosses a
// word. A fill repeats these steps for each element; a clear writes zero to
// every memory word; a flagged or unknown request goes straight to the
// result. The next request is taken in the cycle after the result is loaded.
// Each element costs two word reads through the registered read port, a
// merge, and one or two word writes.
// Reset: rst clears the sequencer, the result valid and both configuration
// registers. The word memory is not cleared; it holds no defined value until
// written.
// Stalls: the result waits in an output register, so a new request is taken
// while an earlier result is still unclaimed; only the hand-off of the next
// result waits for rsp.ready.
//
module packed_field_array import pfa_pkg::*; #(
  parameter int MAX_BYTES        = 1024,
  parameter int MAX_ELEMENT_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  pfa_req_if.sink   req,
  pfa_rsp_if.source rsp,
  pfa_cfg_if.sink   cfg
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  // Configuration writes are taken in any cycle.
  assign cfg.ready = 1'b1;

  // The sequencer owns the handshakes and steps the datapath.
  pfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the registers, the word memory and the result.
  pfa_datapath #(
    .MAX_BYTES        (MAX_BYTES),
    .MAX_ELEMENT_BITS (MAX_ELEMENT_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg.valid),
    .cfg_addr   (cfg.addr),
    .cfg_data   (cfg.data),
    .in_op      (req.op),
    .in_index   (req.element_index),
    .in_value   (req.write_value),
    .cmd        (cmd),
    .sts        (sts),
    .read_value (rsp.read_value),
    .status     (rsp.status)
  );

endmodule
